>>> rtl/core/r2p_pkg.sv
package r2p_pkg;

	// Result field widths (fixed by the output format)
	localparam int RAD_W       = 17;
	localparam int ANG_W       = 17;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - RAD_W - ANG_W;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_H = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_V = 2'd1;

	// CORDIC datapath: fraction bits added below the coordinate, binary angle width
	localparam int CORDIC_FRAC = 16;
	localparam int ZW          = 32;
	localparam int MAX_ITERS   = 32;

	// Angle constants, Q3.13 radians
	localparam logic signed [ANG_W-1:0] ANG_ZERO     = 17'sd0;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI  = 17'sd12868;
	localparam logic signed [ANG_W-1:0] ANG_PI       = 17'sd25736;
	localparam logic signed [ANG_W-1:0] ANG_3HALF_PI = 17'sd38604;
	localparam logic signed [ANG_W-1:0] ANG_MIN      = -17'sd12867;
	localparam int                      ANG_Q_W      = 14;
	localparam logic [15:0]             ANG_LIMIT    = 16'd12867;

	// Binary angle (2^32 per turn) to Q3.13: multiply by pi*2^30 then round at bit 47
	localparam logic [31:0] PI_Q30     = 32'd3373259426;
	localparam logic [63:0] ROUND_HALF = 64'h0000_8000_0000_0000;

	// atan(2^-i) as binary angle, 2^32 per full turn
	localparam logic [ZW-1:0] ATAN_TAB [MAX_ITERS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	// Point classification that rides along the pipeline
	typedef struct packed {
		logic x_zero;
		logic y_zero;
		logic x_neg;
		logic y_pos;
	} flags_t;

endpackage

>>> rtl/core/r2p_cordic.sv
module r2p_cordic #(
	parameter int IN_W  = 18,
	parameter int ITERS = 16,
	parameter int DEPTH = 19
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [IN_W-1:0]        x_in,
	input  logic signed [IN_W-1:0]        y_in,
	output logic signed [r2p_pkg::ZW-1:0] z_out
);

	// Two guard bits cover the CORDIC gain on top of the diagonal
	localparam int XW = IN_W + r2p_pkg::CORDIC_FRAC + 2;

	logic signed [XW-1:0]          x_s [1:DEPTH];
	logic signed [XW-1:0]          y_s [1:DEPTH];
	logic signed [r2p_pkg::ZW-1:0] z_s [1:DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		logic signed [XW-1:0]          xi;
		logic signed [XW-1:0]          yi;
		logic signed [r2p_pkg::ZW-1:0] zi;

		// stage input: scaled coordinates at the head, previous stage elsewhere
		if (k == 0) begin : g_head
			assign xi = XW'(x_in) <<< r2p_pkg::CORDIC_FRAC;
			assign yi = XW'(y_in) <<< r2p_pkg::CORDIC_FRAC;
			assign zi = '0;
		end else begin : g_link
			assign xi = x_s[k];
			assign yi = y_s[k];
			assign zi = z_s[k];
		end

		if (k < ITERS) begin : g_rot
			logic                          dir_up;
			logic signed [XW-1:0]          dx;
			logic signed [XW-1:0]          dy;
			logic signed [r2p_pkg::ZW-1:0] da;

			// rotate toward the x axis: direction from the sign of y
			assign dir_up = !yi[XW-1];
			assign dx     = yi >>> k;
			assign dy     = xi >>> k;
			assign da     = $signed(r2p_pkg::ATAN_TAB[k]);

			always_ff @(posedge clk) begin
				if (adv) begin
					x_s[k+1] <= dir_up ? xi + dx : xi - dx;
					y_s[k+1] <= dir_up ? yi - dy : yi + dy;
					z_s[k+1] <= dir_up ? zi + da : zi - da;
				end
			end
		end else begin : g_pass
			// padding stage, keeps latency equal to the root path
			always_ff @(posedge clk) begin
				if (adv) begin
					x_s[k+1] <= xi;
					y_s[k+1] <= yi;
					z_s[k+1] <= zi;
				end
			end
		end
	end

	assign z_out = z_s[DEPTH];

endmodule

>>> rtl/core/r2p_sqrt.sv
module r2p_sqrt #(
	parameter int SUM_W = 34,
	parameter int DEPTH = 17
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [SUM_W-1:0]     sum_in,
	output logic [SUM_W/2-1:0]   root_out,
	output logic [SUM_W/2+1:0]   rem_out
);

	localparam int RW   = SUM_W / 2;
	localparam int REMW = RW + 2;
	localparam int CW   = REMW + 2;

	logic [SUM_W-1:0] s_s   [1:DEPTH];
	logic [RW-1:0]    q_s   [1:DEPTH];
	logic [REMW-1:0]  rem_s [1:DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		logic [SUM_W-1:0] si;
		logic [RW-1:0]    qi;
		logic [REMW-1:0]  ri;

		if (k == 0) begin : g_head
			assign si = sum_in;
			assign qi = '0;
			assign ri = '0;
		end else begin : g_link
			assign si = s_s[k];
			assign qi = q_s[k];
			assign ri = rem_s[k];
		end

		if (k < RW) begin : g_bit
			logic [CW-1:0] cand;
			logic [CW-1:0] trial;
			logic [CW-1:0] diff;
			logic          take;

			// restoring square root: one root bit per stage
			assign cand  = {ri, si[SUM_W-1 -: 2]};
			assign trial = {2'b00, qi, 2'b01};
			assign diff  = cand - trial;
			assign take  = cand >= trial;

			always_ff @(posedge clk) begin
				if (adv) begin
					s_s[k+1]   <= si << 2;
					q_s[k+1]   <= {qi[RW-2:0], take};
					rem_s[k+1] <= take ? diff[REMW-1:0] : cand[REMW-1:0];
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					s_s[k+1]   <= si;
					q_s[k+1]   <= qi;
					rem_s[k+1] <= ri;
				end
			end
		end
	end

	assign root_out = q_s[DEPTH];
	assign rem_out  = rem_s[DEPTH];

endmodule

>>> rtl/core/rect_to_polar_converter_top.sv
// Rectangular to polar converter.
// Input stream (s_t*): one signed Q8.8 point per transfer. Each point is moved by the
// horizontal and vertical offsets, then converted to a radius (unsigned Q9.8, rounded
// to nearest) and an angle in radians (signed Q3.13, range -pi/2 to 3pi/2).
// Output stream (m_t*): one result per input point, in input order.
// Configuration port (cfg_*): index 0 writes the horizontal offset, index 1 the
// vertical offset; other indexes are dropped. cfg_ready is always high. Write only
// while no point is in flight.
// Throughput: one point per cycle unless the output holds a result that is not taken.
// The pipeline length is set by the CORDIC iteration stages and by the bit-per-stage
// square root of x^2 + y^2, padded to the same depth.
// The pipeline moves as a whole: when the output holds a result that is not taken,
// every stage freezes and s_tready drops in the same cycle, so nothing is lost or
// repeated. Reset clears all valid bits and loads the offsets with 2.0 and 6.0.
module rect_to_polar_converter_top #(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,   // coord_x, coord_y, zero pad
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [r2p_pkg::OUT_TDATA_W-1:0]      m_tdata,   // radius, angle, zero pad
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [r2p_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [COORD_WIDTH-1:0]               cfg_data
);

	localparam int XS_W       = COORD_WIDTH + 1;
	localparam int C_W        = COORD_WIDTH + 2;
	localparam int SUM_W      = (2*COORD_WIDTH + 2 > 64) ? 64 : 2*COORD_WIDTH + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int CORE_DEPTH = (CORDIC_STAGES > ROOT_W + 2) ? CORDIC_STAGES : ROOT_W + 2;
	localparam int SQRT_DEPTH = CORE_DEPTH - 2;
	localparam int CORE_END   = CORE_DEPTH + 2;
	localparam int LATENCY    = CORE_END + 3;

	logic adv;

	// configuration registers
	logic signed [COORD_WIDTH-1:0] off_h_q;
	logic signed [COORD_WIDTH-1:0] off_v_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_h_q <= COORD_WIDTH'(512);
			off_v_q <= COORD_WIDTH'(1536);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				r2p_pkg::REG_OFFSET_H: off_h_q <= cfg_data;
				r2p_pkg::REG_OFFSET_V: off_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits, one per stage; the whole pipe advances unless the output is stuck
	logic [LATENCY:1] vld_s;

	assign adv      = !vld_s[LATENCY] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[LATENCY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LATENCY-1:1], s_tvalid};
		end
	end

	// stage 1: add offsets one bit wider
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [XS_W-1:0]        x_sum_s1;
	logic signed [XS_W-1:0]        y_sum_s1;

	assign coord_x = s_tdata[COORD_WIDTH-1:0];
	assign coord_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_sum_s1 <= XS_W'(coord_x) + XS_W'(off_h_q);
			y_sum_s1 <= XS_W'(coord_y) + XS_W'(off_v_q);
		end
	end

	// stage 2: classify, fold left half-plane onto the right, magnitudes
	logic signed [C_W-1:0] xw;
	logic signed [C_W-1:0] yw;
	logic signed [C_W-1:0] cx;
	logic signed [C_W-1:0] cy;
	logic signed [C_W-1:0] ay_full;
	logic                  x_is_neg;
	logic                  y_is_neg;
	r2p_pkg::flags_t       flags_in;

	r2p_pkg::flags_t       flag_s [2:CORE_END+2];
	logic signed [C_W-1:0] cx_s2;
	logic signed [C_W-1:0] cy_s2;
	logic [XS_W-1:0]       ax_s2;
	logic [XS_W-1:0]       ay_s2;

	assign xw       = C_W'(x_sum_s1);
	assign yw       = C_W'(y_sum_s1);
	assign x_is_neg = x_sum_s1[XS_W-1];
	assign y_is_neg = y_sum_s1[XS_W-1];
	assign cx       = x_is_neg ? -xw : xw;
	assign cy       = x_is_neg ? -yw : yw;
	assign ay_full  = y_is_neg ? -yw : yw;

	always_comb begin
		flags_in.x_zero = (x_sum_s1 == '0);
		flags_in.y_zero = (y_sum_s1 == '0);
		flags_in.x_neg  = x_is_neg;
		flags_in.y_pos  = !y_is_neg && (y_sum_s1 != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s2     <= cx;
			cy_s2     <= cy;
			ax_s2     <= cx[XS_W-1:0];
			ay_s2     <= ay_full[XS_W-1:0];
			flag_s[2] <= flags_in;
		end
	end

	// classification travels alongside the data
	for (genvar k = 3; k <= CORE_END + 2; k++) begin : g_flag
		always_ff @(posedge clk) begin
			if (adv) begin
				flag_s[k] <= flag_s[k-1];
			end
		end
	end

	// stage 3: squares, kept modulo 2^SUM_W
	logic [2*XS_W-1:0] sqx_full;
	logic [2*XS_W-1:0] sqy_full;
	logic [SUM_W-1:0]  sqx_s3;
	logic [SUM_W-1:0]  sqy_s3;

	assign sqx_full = (2*XS_W)'(ax_s2) * (2*XS_W)'(ax_s2);
	assign sqy_full = (2*XS_W)'(ay_s2) * (2*XS_W)'(ay_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s3 <= sqx_full[SUM_W-1:0];
			sqy_s3 <= sqy_full[SUM_W-1:0];
		end
	end

	// stage 4: sum of squares
	logic [SUM_W-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= sqx_s3 + sqy_s3;
		end
	end

	// core: CORDIC angle from stage 2, square root from stage 4, both end at CORE_END
	logic signed [r2p_pkg::ZW-1:0] z_core;
	logic [ROOT_W-1:0]             root_core;
	logic [ROOT_W+1:0]             rem_core;

	r2p_cordic #(
		.IN_W  (C_W),
		.ITERS (CORDIC_STAGES),
		.DEPTH (CORE_DEPTH)
	) u_cordic (
		.clk   (clk),
		.adv   (adv),
		.x_in  (cx_s2),
		.y_in  (cy_s2),
		.z_out (z_core)
	);

	r2p_sqrt #(
		.SUM_W (SUM_W),
		.DEPTH (SQRT_DEPTH)
	) u_sqrt (
		.clk      (clk),
		.adv      (adv),
		.sum_in   (sum_s4),
		.root_out (root_core),
		.rem_out  (rem_core)
	);

	// post stage 1: angle magnitude times pi, round the root
	logic [r2p_pkg::ZW-1:0] z_mag;
	logic [63:0]            prod_full;
	logic [63:0]            prod_sp1;
	logic                   zneg_sp1;
	logic [ROOT_W:0]        radius_sp1;

	assign z_mag     = z_core[r2p_pkg::ZW-1] ? -z_core : z_core;
	assign prod_full = 64'(z_mag) * 64'(r2p_pkg::PI_Q30);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_sp1   <= prod_full;
			zneg_sp1   <= z_core[r2p_pkg::ZW-1];
			radius_sp1 <= (rem_core > {2'b00, root_core}) ?
				(ROOT_W+1)'(root_core) + (ROOT_W+1)'(1) : (ROOT_W+1)'(root_core);
		end
	end

	// post stage 2: round to Q3.13 and clamp below pi/2
	logic [63:0]                    prod_rnd;
	logic [15:0]                    q_raw;
	logic [r2p_pkg::ANG_Q_W-1:0]    q_sp2;
	logic                           zneg_sp2;
	logic [ROOT_W:0]                radius_sp2;

	assign prod_rnd = prod_sp1 + r2p_pkg::ROUND_HALF;
	assign q_raw    = prod_rnd[63:48];

	always_ff @(posedge clk) begin
		if (adv) begin
			q_sp2      <= (q_raw > r2p_pkg::ANG_LIMIT) ?
				r2p_pkg::ANG_LIMIT[r2p_pkg::ANG_Q_W-1:0] : q_raw[r2p_pkg::ANG_Q_W-1:0];
			zneg_sp2   <= zneg_sp1;
			radius_sp2 <= radius_sp1;
		end
	end

	// post stage 3 (output register): sign, half-plane, axis cases
	r2p_pkg::flags_t                     fl;
	logic signed [r2p_pkg::ANG_W-1:0]    ang_mag;
	logic signed [r2p_pkg::ANG_W-1:0]    ang_signed;
	logic signed [r2p_pkg::ANG_W-1:0]    ang_cordic;
	logic signed [r2p_pkg::ANG_W-1:0]    ang_next;
	logic signed [r2p_pkg::ANG_W-1:0]    angle_sp3;
	logic [r2p_pkg::RAD_W-1:0]           radius_sp3;

	assign fl         = flag_s[CORE_END+2];
	assign ang_mag    = r2p_pkg::ANG_W'({1'b0, q_sp2});
	assign ang_signed = zneg_sp2 ? -ang_mag : ang_mag;
	assign ang_cordic = fl.x_neg ? ang_signed + r2p_pkg::ANG_PI : ang_signed;

	always_comb begin
		if (fl.x_zero) begin
			if (fl.y_pos) begin
				ang_next = r2p_pkg::ANG_HALF_PI;
			end else if (fl.y_zero) begin
				ang_next = r2p_pkg::ANG_ZERO;
			end else begin
				ang_next = r2p_pkg::ANG_3HALF_PI;
			end
		end else if (fl.y_zero) begin
			ang_next = fl.x_neg ? r2p_pkg::ANG_PI : r2p_pkg::ANG_ZERO;
		end else begin
			ang_next = ang_cordic;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_sp3  <= ang_next;
			radius_sp3 <= r2p_pkg::RAD_W'(radius_sp2);
		end
	end

	assign m_tdata = {{r2p_pkg::OUT_PAD_W{1'b0}}, angle_sp3, radius_sp3};

`ifndef SYNTHESIS
	// a frozen pipe must not gain or lose items
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline valid bits changed while stalled");

	// delivered angle stays inside (-pi/2, 3pi/2]
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (angle_sp3 >= r2p_pkg::ANG_MIN) && (angle_sp3 <= r2p_pkg::ANG_3HALF_PI))
		else $error("angle out of range");
`endif

endmodule
